/* sv/tlvd_pkg.sv */
package tlvd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_VALUE   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  localparam logic [1:0] EV_HDR_BYTE = 2'd0;
  localparam logic [1:0] EV_HDR_DONE = 2'd1;
  localparam logic [1:0] EV_VALUE    = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  localparam logic [1:0] CFG_TYPE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_LENGTH_SIZE = 2'd1;
  localparam logic [1:0] CFG_LENGTH_INCL = 2'd2;
  localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd3;

  localparam logic [1:0] SIZE_CODE_ONE = 2'd0;
  localparam logic [1:0] SIZE_CODE_TWO = 2'd1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] bytes_remaining;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [31:0] record_type;
    logic [31:0]        value_length;
    logic [7:0]         value_byte;
    logic               last_value_byte;
  } out_beat_t;

  // field width in bytes, code three counts as four
  function automatic logic [3:0] size_of_code(input logic [1:0] code);
    logic [3:0] size;
    unique case (code)
      SIZE_CODE_ONE: size = 4'd1;
      SIZE_CODE_TWO: size = 4'd2;
      default:       size = 4'd4;
    endcase
    return size;
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] pos, input logic big_endian);
    logic [31:0] res;
    if (big_endian) begin
      res = {acc[23:0], b};
    end else begin
      res = acc | ({24'd0, b} << {pos, 3'b000});
    end
    return res;
  endfunction

endpackage

/* sv/tlvd_stream_if.sv */
interface tlvd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/tlv_record_deframer_top.sv */
// a result is registered and appears on out_o the cycle after its beat is accepted
// throughput: one input beat per cycle while out_o is ready; in_i stalls only
//   while a held result is not taken
// reset: asynchronous active low; clears phase, counters, accumulators and the
//   output valid, and sets the registers to one-byte fields, exclusive, big endian
module tlv_record_deframer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [1:0]          cfg_wdata_i,
  tlvd_stream_if.sink         in_i,
  tlvd_stream_if.source       out_o
);

  logic [1:0] type_size_q, length_size_q;
  logic       length_incl_q, big_endian_q;

  tlvd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [31:0] type_acc_q, type_acc_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] vleft_q, vleft_d;

  logic                out_valid_q;
  tlvd_pkg::out_beat_t out_q, res;
  logic                res_valid;
  logic                accept;

  logic [7:0]  b;
  logic [31:0] rem;
  logic [3:0]  tsize, lsize, hsize;
  logic [3:0]  len_pos;
  logic [1:0]  pos;
  logic        in_type, short_hdr, hdr_final, too_small, too_long, bad, rem_gt1;
  logic [31:0] type_nxt, len_nxt, t_ext, len_adj;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  assign b   = in_i.payload.data_byte;
  assign rem = in_i.payload.bytes_remaining;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_size_q   <= 2'd0;
      length_size_q <= 2'd0;
      length_incl_q <= 1'b0;
      big_endian_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tlvd_pkg::CFG_TYPE_SIZE:   type_size_q   <= cfg_wdata_i;
        tlvd_pkg::CFG_LENGTH_SIZE: length_size_q <= cfg_wdata_i;
        tlvd_pkg::CFG_LENGTH_INCL: length_incl_q <= cfg_wdata_i[0];
        tlvd_pkg::CFG_BIG_ENDIAN:  big_endian_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // header decode for the current beat
  always_comb begin
    tsize   = tlvd_pkg::size_of_code(type_size_q);
    lsize   = tlvd_pkg::size_of_code(length_size_q);
    hsize   = tsize + lsize;
    in_type = {1'b0, hcnt_q} < tsize;
    len_pos = {1'b0, hcnt_q} - tsize;
    pos     = in_type ? hcnt_q[1:0] : len_pos[1:0];
    type_nxt = in_type ? tlvd_pkg::put_byte(type_acc_q, b, pos, big_endian_q) : type_acc_q;
    len_nxt  = in_type ? len_acc_q : tlvd_pkg::put_byte(len_acc_q, b, pos, big_endian_q);
    short_hdr = (hcnt_q == 3'd0) && (rem < {28'd0, hsize});
    hdr_final = ({1'b0, hcnt_q} + 4'd1) >= hsize;
    rem_gt1   = rem > 32'd1;
    t_ext = type_nxt;
    if (tsize == 4'd1 && type_nxt[7]) t_ext = type_nxt | 32'hFFFF_FF00;
    if (tsize == 4'd2 && type_nxt[15]) t_ext = type_nxt | 32'hFFFF_0000;
    too_small = len_nxt < {28'd0, hsize};
    len_adj   = length_incl_q ? (len_nxt - {28'd0, hsize}) : len_nxt;
    // zero remaining wraps in the model and never counts as too long
    too_long  = (rem != 32'd0) && ((rem - 32'd1) < len_adj);
    bad       = (length_incl_q && too_small) || too_long;
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    type_acc_d = type_acc_q;
    len_acc_d  = len_acc_q;
    vleft_d    = vleft_q;
    if (accept) begin
      unique case (phase_q)
        tlvd_pkg::PH_DISCARD: begin
          if (!rem_gt1) begin
            phase_d    = tlvd_pkg::PH_HEADER;
            hcnt_d     = 3'd0;
            type_acc_d = 32'd0;
            len_acc_d  = 32'd0;
          end
        end
        tlvd_pkg::PH_VALUE: begin
          if (vleft_q <= 32'd1) begin
            vleft_d    = 32'd0;
            phase_d    = tlvd_pkg::PH_HEADER;
            hcnt_d     = 3'd0;
            type_acc_d = 32'd0;
            len_acc_d  = 32'd0;
          end else begin
            vleft_d = vleft_q - 32'd1;
          end
        end
        default: begin
          if (short_hdr || (hdr_final && bad)) begin
            phase_d    = rem_gt1 ? tlvd_pkg::PH_DISCARD : tlvd_pkg::PH_HEADER;
            hcnt_d     = 3'd0;
            type_acc_d = 32'd0;
            len_acc_d  = 32'd0;
            vleft_d    = 32'd0;
          end else if (!hdr_final) begin
            hcnt_d     = hcnt_q + 3'd1;
            type_acc_d = type_nxt;
            len_acc_d  = len_nxt;
          end else begin
            phase_d    = (len_adj != 32'd0) ? tlvd_pkg::PH_VALUE : tlvd_pkg::PH_HEADER;
            hcnt_d     = 3'd0;
            type_acc_d = 32'd0;
            len_acc_d  = 32'd0;
            vleft_d    = len_adj;
          end
        end
      endcase
    end
  end

  // result of the current beat
  always_comb begin
    res       = '0;
    res_valid = 1'b1;
    unique case (phase_q)
      tlvd_pkg::PH_DISCARD: res_valid = 1'b0;
      tlvd_pkg::PH_VALUE: begin
        res.event_res       = tlvd_pkg::EV_VALUE;
        res.value_byte      = b;
        res.last_value_byte = vleft_q <= 32'd1;
      end
      default: begin
        if (short_hdr || (hdr_final && bad)) begin
          res.event_res = tlvd_pkg::EV_ERROR;
        end else if (hdr_final) begin
          res.event_res    = tlvd_pkg::EV_HDR_DONE;
          res.record_type  = t_ext;
          res.value_length = len_adj;
        end else begin
          res.event_res = tlvd_pkg::EV_HDR_BYTE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tlvd_pkg::PH_HEADER;
      hcnt_q      <= 3'd0;
      type_acc_q  <= 32'd0;
      len_acc_q   <= 32'd0;
      vleft_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      type_acc_q <= type_acc_d;
      len_acc_q  <= len_acc_d;
      vleft_q    <= vleft_d;
      if (accept) begin
        out_valid_q <= res_valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

endmodule

/* test/tlv_record_deframer_top_tb.sv */
`timescale 1ns / 1ps

module tlv_record_deframer_top_tb;

  localparam logic [1:0] SIZE_CODE_FOUR = 2'd2;
  localparam logic [1:0] SIZE_CODE_WIDE = 2'd3;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_BYTES = 80;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum {
    BUF_CLEAN,
    BUF_SHORT_HDR,
    BUF_LONG_VALUE,
    BUF_INCL_SMALL,
    BUF_NOISE
  } buf_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [1:0] cfg_wdata_i;

  tlvd_stream_if #(.payload_t(tlvd_pkg::in_beat_t))  in_bus ();
  tlvd_stream_if #(.payload_t(tlvd_pkg::out_beat_t)) out_bus ();

  tlv_record_deframer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register copies seen by the deframer model
  logic [1:0] type_code;
  logic [1:0] len_code;
  logic       incl_mode;
  logic       msb_first;

  // deframer model state
  tlvd_pkg::phase_e ph;
  int          hdr_count;
  logic [31:0] type_acc;
  logic [31:0] len_acc;
  logic [31:0] value_left;

  tlvd_pkg::in_beat_t  byte_queue[$];
  tlvd_pkg::out_beat_t predicted_events[$];
  logic [7:0] frame_bytes[$];

  int fail_count = 0;
  int gap_cnt = 0;
  int hold_cnt = 0;
  int stall_cycles = 0;
  bit in_idle_en;
  bit out_idle_en;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;

  logic [1:0] preset_type [8] = '{tlvd_pkg::SIZE_CODE_ONE, SIZE_CODE_FOUR,
                                  tlvd_pkg::SIZE_CODE_TWO, SIZE_CODE_FOUR,
                                  tlvd_pkg::SIZE_CODE_ONE, SIZE_CODE_WIDE,
                                  tlvd_pkg::SIZE_CODE_TWO, tlvd_pkg::SIZE_CODE_ONE};
  logic [1:0] preset_len [8] = '{tlvd_pkg::SIZE_CODE_ONE, SIZE_CODE_FOUR,
                                 tlvd_pkg::SIZE_CODE_TWO, tlvd_pkg::SIZE_CODE_ONE,
                                 SIZE_CODE_FOUR, SIZE_CODE_WIDE,
                                 SIZE_CODE_FOUR, tlvd_pkg::SIZE_CODE_TWO};
  logic preset_incl [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic preset_msb [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  function automatic int field_bytes(input logic [1:0] code);
    case (code)
      tlvd_pkg::SIZE_CODE_ONE: return 1;
      tlvd_pkg::SIZE_CODE_TWO: return 2;
      default:                 return 4;
    endcase
  endfunction

  function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b,
                                           input int pos);
    if (msb_first) return {acc[23:0], b};
    return acc | ({24'd0, b} << (8 * (pos % 4)));
  endfunction

  task automatic restart_header();
    ph = tlvd_pkg::PH_HEADER;
    hdr_count = 0;
    type_acc = '0;
    len_acc = '0;
  endtask

  task automatic take_error(input logic [31:0] rem);
    restart_header();
    value_left = '0;
    if (rem > 1) ph = tlvd_pkg::PH_DISCARD;
  endtask

  task automatic deframe_byte(input tlvd_pkg::in_beat_t ib);
    tlvd_pkg::out_beat_t r;
    int          tsz;
    int          hsz;
    int          cnt;
    logic [31:0] t;
    logic [31:0] len;
    logic        bad;
    tsz = field_bytes(type_code);
    hsz = tsz + field_bytes(len_code);
    cnt = hdr_count;
    r = '0;
    if (ph == tlvd_pkg::PH_DISCARD) begin
      // rest of a bad buffer is dropped silently
      if (ib.bytes_remaining <= 1) restart_header();
    end else begin
      if (ph == tlvd_pkg::PH_VALUE) begin
        r.event_res = tlvd_pkg::EV_VALUE;
        r.value_byte = ib.data_byte;
        if (value_left <= 1) begin
          r.last_value_byte = 1'b1;
          value_left = '0;
          restart_header();
        end else begin
          value_left = value_left - 1;
        end
      end else if (cnt == 0 && ib.bytes_remaining < hsz) begin
        r.event_res = tlvd_pkg::EV_ERROR;
        take_error(ib.bytes_remaining);
      end else begin
        if (cnt < tsz) type_acc = shift_in(type_acc, ib.data_byte, cnt);
        else len_acc = shift_in(len_acc, ib.data_byte, cnt - tsz);
        if (cnt + 1 < hsz) begin
          r.event_res = tlvd_pkg::EV_HDR_BYTE;
          hdr_count = cnt + 1;
        end else begin
          t = type_acc;
          len = len_acc;
          bad = 1'b0;
          if (tsz == 1 && t[7]) t[31:8] = '1;
          if (tsz == 2 && t[15]) t[31:16] = '1;
          if (incl_mode) begin
            if (len < hsz) bad = 1'b1;
            else len = len - hsz;
          end
          // bytes after this one must hold the whole value
          if (!bad && ({1'b0, ib.bytes_remaining} - 33'd1) < {1'b0, len}) bad = 1'b1;
          if (bad) begin
            r.event_res = tlvd_pkg::EV_ERROR;
            take_error(ib.bytes_remaining);
          end else begin
            r.event_res = tlvd_pkg::EV_HDR_DONE;
            r.record_type = t;
            r.value_length = len;
            restart_header();
            value_left = len;
            if (len != 0) ph = tlvd_pkg::PH_VALUE;
          end
        end
      end
      predicted_events.push_back(r);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // byte source: a beat is never withdrawn once offered
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) deframe_byte(in_bus.payload);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_bus.valid <= 1'b0;
        end else if (byte_queue.size() != 0 && in_idle_en && $urandom_range(0, 5) == 0) begin
          gap_cnt <= $urandom_range(0, 14);
          in_bus.valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_bus.payload <= byte_queue.pop_front();
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  tlvd_pkg::out_beat_t exp_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d",
                   $time, out_bus.payload.event_res);
          fail_count++;
        end else begin
          exp_beat = predicted_events.pop_front();
          check_field("event_res", 32'(exp_beat.event_res),
                      32'(out_bus.payload.event_res));
          check_field("record_type", exp_beat.record_type, out_bus.payload.record_type);
          check_field("value_length", exp_beat.value_length, out_bus.payload.value_length);
          check_field("value_byte", 32'(exp_beat.value_byte),
                      32'(out_bus.payload.value_byte));
          check_field("last_value_byte", 32'(exp_beat.last_value_byte),
                      32'(out_bus.payload.last_value_byte));
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        // long back-pressure so the block fills up and stalls its input
        long_hold_taken <= 1'b1;
        hold_cnt <= LONG_HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_bus.ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        hold_cnt <= $urandom_range(0, 14);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tlv_record_deframer_top test failed");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic [31:0] rem);
    byte_queue.push_back('{data_byte: b, bytes_remaining: rem});
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_bus.valid || predicted_events.size() != 0)
      @(posedge clk_i);
    // a discarded byte may still be in flight with nothing expected
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tlvd_pkg::CFG_TYPE_SIZE:   type_code = val;
      tlvd_pkg::CFG_LENGTH_SIZE: len_code = val;
      tlvd_pkg::CFG_LENGTH_INCL: incl_mode = val[0];
      default:                   msb_first = val[0];
    endcase
  endtask

  task automatic apply_setting(input logic [1:0] tcode, input logic [1:0] lcode,
                               input logic incl, input logic msb);
    write_reg(tlvd_pkg::CFG_TYPE_SIZE, tcode);
    write_reg(tlvd_pkg::CFG_LENGTH_SIZE, lcode);
    write_reg(tlvd_pkg::CFG_LENGTH_INCL, {1'b0, incl});
    write_reg(tlvd_pkg::CFG_BIG_ENDIAN, {1'b0, msb});
  endtask

  task automatic put_field(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      if (msb_first) frame_bytes.push_back(v[8 * (n - 1 - i) +: 8]);
      else frame_bytes.push_back(v[8 * i +: 8]);
    end
  endtask

  task automatic add_record(input int vlen, input logic [31:0] lval);
    put_field($urandom, field_bytes(type_code));
    put_field(lval, field_bytes(len_code));
    repeat (vlen) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic gen_buffer();
    buf_kind_e   kind;
    int          nrec;
    int          hsz;
    int          vlen;
    logic [31:0] lval;
    logic [31:0] start_rem;
    hsz = field_bytes(type_code) + field_bytes(len_code);
    frame_bytes.delete();
    case ($urandom_range(0, 9))
      0:       kind = BUF_SHORT_HDR;
      1:       kind = BUF_LONG_VALUE;
      2:       kind = BUF_INCL_SMALL;
      3:       kind = BUF_NOISE;
      default: kind = BUF_CLEAN;
    endcase
    if (kind == BUF_NOISE) begin
      repeat ($urandom_range(1, 12))
        push_item(8'($urandom_range(0, 255)), $urandom_range(1, 8));
    end else begin
      nrec = $urandom_range(1, 4);
      for (int r = 0; r < nrec; r++) begin
        vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
        lval = vlen + (incl_mode ? hsz : 0);
        if (kind == BUF_INCL_SMALL && r == nrec - 1) begin
          // length below the header size
          lval = $urandom_range(0, hsz - 1);
          vlen = incl_mode ? $urandom_range(0, 3) : lval;
        end
        add_record(vlen, lval);
      end
      if (kind == BUF_LONG_VALUE) begin
        // value runs past the end of the buffer
        vlen = $urandom_range(1, 40);
        lval = ($urandom_range(0, 3) == 0) ? $urandom : vlen + (incl_mode ? hsz : 0);
        add_record($urandom_range(0, vlen - 1), lval);
      end
      if (kind == BUF_SHORT_HDR)
        repeat ($urandom_range(1, hsz - 1)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      start_rem = frame_bytes.size();
      if (kind == BUF_CLEAN && $urandom_range(0, 7) == 0)
        start_rem = $urandom_range(32'hFFFF_FFFF, frame_bytes.size());
      foreach (frame_bytes[i]) push_item(frame_bytes[i], start_rem - i);
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.payload = '0;
    out_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = tlvd_pkg::CFG_TYPE_SIZE;
    cfg_wdata_i = tlvd_pkg::SIZE_CODE_ONE;
    rst_ni = 1'b0;
    type_code = tlvd_pkg::SIZE_CODE_ONE;
    len_code = tlvd_pkg::SIZE_CODE_ONE;
    incl_mode = 1'b0;
    msb_first = 1'b1;
    restart_header();
    value_left = '0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-byte fields, exclusive, big endian
    apply_setting(tlvd_pkg::SIZE_CODE_ONE, tlvd_pkg::SIZE_CODE_ONE, 1'b0, 1'b1);
    push_item(8'h80, 32'd6);
    push_item(8'h00, 32'd5);            // negative type, empty value
    push_item(8'h7F, 32'd4);
    push_item(8'h01, 32'd3);
    push_item(8'hFF, 32'd2);
    push_item(8'h00, 32'd1);            // header cut short at the buffer end
    push_item(8'hFF, 32'hFFFF_FFFF);
    push_item(8'h01, 32'hFFFF_FFFE);
    push_item(8'hAA, 32'hFFFF_FFFD);
    push_item(8'h01, 32'd4);
    push_item(8'h05, 32'd3);            // value longer than the buffer
    push_item(8'h11, 32'd2);
    push_item(8'h22, 32'd1);
    push_item(8'h12, 32'd9);
    wait_idle();
    // widen the type while a header is half gathered
    write_reg(tlvd_pkg::CFG_TYPE_SIZE, tlvd_pkg::SIZE_CODE_TWO);
    push_item(8'h34, 32'd8);
    push_item(8'h00, 32'd7);
    wait_idle();
    write_reg(tlvd_pkg::CFG_LENGTH_INCL, 2'd1);
    push_item(8'h00, 32'd3);
    push_item(8'h00, 32'd2);
    push_item(8'h02, 32'd1);            // inclusive length below header size
    wait_idle();
    write_reg(tlvd_pkg::CFG_BIG_ENDIAN, 2'd0);
    write_reg(tlvd_pkg::CFG_TYPE_SIZE, SIZE_CODE_WIDE);
    push_item(8'h01, 32'd7);
    push_item(8'h02, 32'd6);
    push_item(8'h03, 32'd5);
    push_item(8'h84, 32'd4);
    push_item(8'h06, 32'd3);
    push_item(8'h5A, 32'd2);
    push_item(8'h00, 32'd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 8) begin
        apply_setting(preset_type[p], preset_len[p], preset_incl[p], preset_msb[p]);
      end else begin
        apply_setting(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      in_idle_en = (p < NUM_PHASES - 2) && (p % 3 != 1);
      out_idle_en = (p < NUM_PHASES - 2) && (p % 3 != 2);
      long_hold_req = (p == 2);
      while (byte_queue.size() < PHASE_BYTES) gen_buffer();
    end

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tlv_record_deframer_top test passed");
    end else begin
      $display("tlv_record_deframer_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tlvd_pkg.sv
sv/tlvd_stream_if.sv
sv/tlv_record_deframer_top.sv
test/tlv_record_deframer_top_tb.sv
